// ----- hdl/rpf_pkg.sv -----
`default_nettype none
package rpf_pkg;

  // sizing
  localparam int MAX_PAYLOAD_DEFAULT = 32;
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 8;
  localparam int KIND_W   = 2;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;
  localparam int CRC_W    = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TX_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TX_BYTE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RX_START = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TX_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RX_BYTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TX_BUSY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RX_BUSY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 3'd5;

  // framing bytes and crc polynomial
  localparam logic [DATA_W-1:0] PREAMBLE_BYTE = 8'hAA;
  localparam logic [DATA_W-1:0] SYNC_HI_BYTE  = 8'h2D;
  localparam logic [DATA_W-1:0] SYNC_LO_BYTE  = 8'hD4;
  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TX,
    MODE_RX_LEN,
    MODE_RX_BODY
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_HDR,
    S_ECHO,
    S_TAIL,
    S_RD_ADDR,
    S_RD_OUT,
    S_STAT
  } state_t;

  // control from the sequencer to the crc unit
  typedef struct packed {
    logic start;
    logic from_zero;
    logic clear;
  } crc_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/rpf_in_if.sv -----
`default_nettype none
interface rpf_in_if;
  logic                          valid;
  logic                          ready;
  logic [rpf_pkg::CMD_W-1:0]     cmd;
  logic [rpf_pkg::VALUE_W-1:0]   value;

  modport source (output valid, cmd, value, input ready);
  modport sink (input valid, cmd, value, output ready);
endinterface
`default_nettype wire

// ----- hdl/rpf_out_if.sv -----
`default_nettype none
interface rpf_out_if;
  logic                           valid;
  logic                           ready;
  logic [rpf_pkg::KIND_W-1:0]     kind;
  logic [rpf_pkg::DATA_W-1:0]     data;
  logic [rpf_pkg::STATUS_W-1:0]   status;
  logic                           last;

  modport source (output valid, kind, data, status, last, input ready);
  modport sink (input valid, kind, data, status, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/rpf_crc_unit.sv -----
`default_nettype none
module rpf_crc_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rpf_pkg::crc_ctl_t             ctl,
  input  wire logic [rpf_pkg::DATA_W-1:0]    din,
  output logic      [rpf_pkg::CRC_W-1:0]     crc,
  output logic                               busy
);

  logic [rpf_pkg::DATA_W-1:0] shreg;
  logic [2:0]                 bit_cnt;
  logic                       fb;

  // msb-first feedback, one bit per cycle
  assign fb = crc[rpf_pkg::CRC_W-1] ^ shreg[rpf_pkg::DATA_W-1];

  // running crc and bit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= '0;
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (ctl.clear) begin
      crc  <= '0;
      busy <= 1'b0;
    end else if (ctl.start) begin
      if (ctl.from_zero) begin
        crc <= '0;
      end
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      crc     <= {crc[rpf_pkg::CRC_W-2:0], 1'b0} ^ (fb ? rpf_pkg::CRC_POLY : '0);
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  // data shifter
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      shreg <= din;
    end else if (busy) begin
      shreg <= {shreg[rpf_pkg::DATA_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rpf_payload_ram.sv -----
`default_nettype none
module rpf_payload_ram #(
  parameter int DEPTH  = rpf_pkg::MAX_PAYLOAD_DEFAULT,
  parameter int ADDR_W = 5
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [rpf_pkg::DATA_W-1:0]  wdata,
  input  wire logic [ADDR_W-1:0]           raddr,
  output logic      [rpf_pkg::DATA_W-1:0]  rdata
);

  logic [rpf_pkg::DATA_W-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/radio_packet_framer_crc16_top.sv -----
`default_nettype none
// status-only beats pass through the S_STAT state into the result register once the
// output is free; crc beats wait in S_CRC on the bit-serial crc unit, so a transmit result
// follows the crc; receive completion replays the payload via S_RD_ADDR and S_RD_OUT per byte
// a new input beat is taken only in S_IDLE, not while an earlier beat is still in progress
// reset: synchronous rst returns the link to idle and clears counters and crc;
// the payload buffer is not cleared
module radio_packet_framer_crc16_top #(
  parameter int MAX_PAYLOAD = rpf_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rpf_in_if.sink     req,
  rpf_out_if.source  rsp
);

  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int CNT_W  = $clog2(MAX_PAYLOAD + 2);
  localparam int IDX_W  = (CNT_W > 3) ? CNT_W : 3;
  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  rpf_pkg::state_t state, state_next, after_crc, after_crc_next;
  rpf_pkg::mode_t  mode, mode_next;

  logic [CNT_W-1:0]             byte_count, byte_count_next;
  logic [LEN_W-1:0]             frame_length, frame_length_next;
  logic [IDX_W-1:0]             idx, idx_next;
  logic [rpf_pkg::DATA_W-1:0]   crc_low, crc_low_next;
  logic [rpf_pkg::DATA_W-1:0]   value_q, value_q_next;
  logic [rpf_pkg::DATA_W-1:0]   stat_data, stat_data_next;
  logic [rpf_pkg::STATUS_W-1:0] stat_code, stat_code_next;

  logic                         out_valid;
  logic                         load;
  logic [rpf_pkg::KIND_W-1:0]   kind_next;
  logic [rpf_pkg::DATA_W-1:0]   data_next;
  logic [rpf_pkg::STATUS_W-1:0] status_next;
  logic                         last_next;

  rpf_pkg::crc_ctl_t            crc_ctl;
  logic [rpf_pkg::DATA_W-1:0]   crc_din;
  logic [rpf_pkg::CRC_W-1:0]    crc;
  logic                         crc_busy;

  logic                         ram_we;
  logic [rpf_pkg::DATA_W-1:0]   ram_rdata;

  logic                         accept;
  logic                         slot_free;
  logic [CNT_W-1:0]             len_cnt;
  logic [IDX_W-1:0]             len_idx;
  logic [rpf_pkg::DATA_W-1:0]   len_byte;
  logic [LEN_W-1:0]             clamped_len;
  logic [rpf_pkg::STATUS_W-1:0] busy_code;
  logic [IDX_W-1:0]             idx_inc;

  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign len_cnt   = CNT_W'(frame_length);
  assign len_idx   = IDX_W'(frame_length);
  assign len_byte  = rpf_pkg::DATA_W'(frame_length);
  assign idx_inc   = idx + IDX_W'(1);
  assign busy_code = (mode == rpf_pkg::MODE_TX) ? rpf_pkg::ST_TX_BUSY : rpf_pkg::ST_RX_BUSY;

  // receive length clamp
  assign clamped_len = (req.value > rpf_pkg::DATA_W'(MAX_PAYLOAD)) ?
                       LEN_W'(MAX_PAYLOAD) : req.value[LEN_W-1:0];

  assign ram_we = accept && (req.cmd == rpf_pkg::CMD_RX_BYTE)
                  && (mode == rpf_pkg::MODE_RX_BODY) && (byte_count < len_cnt);

  rpf_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .din  (crc_din),
    .crc  (crc),
    .busy (crc_busy)
  );

  rpf_payload_ram #(
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_count[ADDR_W-1:0]),
    .wdata (req.value),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rpf_pkg::S_IDLE;
      after_crc    <= rpf_pkg::S_IDLE;
      mode         <= rpf_pkg::MODE_IDLE;
      byte_count   <= '0;
      frame_length <= '0;
      idx          <= '0;
      crc_low      <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      after_crc    <= after_crc_next;
      mode         <= mode_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      idx          <= idx_next;
      crc_low      <= crc_low_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    value_q   <= value_q_next;
    stat_data <= stat_data_next;
    stat_code <= stat_code_next;
    if (load) begin
      rsp.kind   <= kind_next;
      rsp.data   <= data_next;
      rsp.status <= status_next;
      rsp.last   <= last_next;
    end
  end

  assign rsp.valid = out_valid;
  assign req.ready = (state == rpf_pkg::S_IDLE);

  // next state, decode and result selection
  always_comb begin
    state_next        = state;
    after_crc_next    = after_crc;
    mode_next         = mode;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    idx_next          = idx;
    crc_low_next      = crc_low;
    value_q_next      = value_q;
    stat_data_next    = stat_data;
    stat_code_next    = stat_code;
    crc_ctl           = '0;
    crc_din           = req.value;
    load              = 1'b0;
    kind_next         = rpf_pkg::KIND_TX_BYTE;
    data_next         = '0;
    status_next       = rpf_pkg::ST_OK;
    last_next         = 1'b0;

    unique case (state)
      rpf_pkg::S_IDLE: begin
        if (accept) begin
          value_q_next   = req.value;
          stat_data_next = '0;
          unique case (req.cmd)
            rpf_pkg::CMD_TX_START: begin
              if (mode != rpf_pkg::MODE_IDLE) begin
                stat_code_next = busy_code;
                state_next     = rpf_pkg::S_STAT;
              end else if (req.value > rpf_pkg::DATA_W'(MAX_PAYLOAD)) begin
                stat_code_next = rpf_pkg::ST_TOO_LONG;
                state_next     = rpf_pkg::S_STAT;
              end else begin
                frame_length_next = req.value[LEN_W-1:0];
                byte_count_next   = '0;
                mode_next         = rpf_pkg::MODE_TX;
                crc_ctl.start     = 1'b1;
                crc_ctl.from_zero = 1'b1;
                idx_next          = '0;
                after_crc_next    = rpf_pkg::S_HDR;
                state_next        = rpf_pkg::S_CRC;
              end
            end
            rpf_pkg::CMD_TX_BYTE: begin
              if (mode != rpf_pkg::MODE_TX) begin
                stat_code_next = rpf_pkg::ST_UNEXPECTED;
                state_next     = rpf_pkg::S_STAT;
              end else begin
                byte_count_next = byte_count + CNT_W'(1);
                crc_ctl.start   = 1'b1;
                after_crc_next  = rpf_pkg::S_ECHO;
                state_next      = rpf_pkg::S_CRC;
              end
            end
            rpf_pkg::CMD_RX_START: begin
              if (mode != rpf_pkg::MODE_IDLE) begin
                stat_code_next = busy_code;
              end else begin
                mode_next       = rpf_pkg::MODE_RX_LEN;
                byte_count_next = '0;
                crc_ctl.clear   = 1'b1;
                stat_code_next  = rpf_pkg::ST_OK;
              end
              state_next = rpf_pkg::S_STAT;
            end
            rpf_pkg::CMD_RX_BYTE: begin
              if (mode == rpf_pkg::MODE_RX_LEN) begin
                frame_length_next = clamped_len;
                crc_din           = rpf_pkg::DATA_W'(clamped_len);
                crc_ctl.start     = 1'b1;
                crc_ctl.from_zero = 1'b1;
                byte_count_next   = '0;
                mode_next         = rpf_pkg::MODE_RX_BODY;
                after_crc_next    = rpf_pkg::S_IDLE;
                state_next        = rpf_pkg::S_CRC;
              end else if (mode == rpf_pkg::MODE_RX_BODY) begin
                if (byte_count < len_cnt) begin
                  crc_ctl.start   = 1'b1;
                  byte_count_next = byte_count + CNT_W'(1);
                  after_crc_next  = rpf_pkg::S_IDLE;
                  state_next      = rpf_pkg::S_CRC;
                end else if (byte_count == len_cnt) begin
                  crc_low_next    = req.value;
                  byte_count_next = byte_count + CNT_W'(1);
                end else begin
                  mode_next       = rpf_pkg::MODE_IDLE;
                  byte_count_next = '0;
                  if ({req.value, crc_low} == crc) begin
                    stat_data_next = len_byte;
                    stat_code_next = rpf_pkg::ST_OK;
                    idx_next       = '0;
                    state_next     = (frame_length == '0) ? rpf_pkg::S_STAT
                                                          : rpf_pkg::S_RD_ADDR;
                  end else begin
                    stat_code_next = rpf_pkg::ST_CRC_ERR;
                    state_next     = rpf_pkg::S_STAT;
                  end
                end
              end
            end
            rpf_pkg::CMD_STOP: begin
              mode_next       = rpf_pkg::MODE_IDLE;
              byte_count_next = '0;
            end
            default: begin
              stat_code_next = rpf_pkg::ST_UNEXPECTED;
              state_next     = rpf_pkg::S_STAT;
            end
          endcase
        end
      end

      // wait for the bit-serial crc to finish
      rpf_pkg::S_CRC: begin
        if (!crc_busy) begin
          state_next = after_crc;
        end
      end

      // preamble, sync word and length
      rpf_pkg::S_HDR: begin
        if (slot_free) begin
          load      = 1'b1;
          kind_next = rpf_pkg::KIND_TX_BYTE;
          priority if (idx < IDX_W'(3)) begin
            data_next = rpf_pkg::PREAMBLE_BYTE;
          end else if (idx == IDX_W'(3)) begin
            data_next = rpf_pkg::SYNC_HI_BYTE;
          end else if (idx == IDX_W'(4)) begin
            data_next = rpf_pkg::SYNC_LO_BYTE;
          end else begin
            data_next = len_byte;
          end
          idx_next = idx_inc;
          if (idx == IDX_W'(5)) begin
            idx_next = '0;
            if (frame_length == '0) begin
              mode_next  = rpf_pkg::MODE_IDLE;
              state_next = rpf_pkg::S_TAIL;
            end else begin
              last_next  = 1'b1;
              state_next = rpf_pkg::S_IDLE;
            end
          end
        end
      end

      // payload byte pass-through
      rpf_pkg::S_ECHO: begin
        if (slot_free) begin
          load      = 1'b1;
          kind_next = rpf_pkg::KIND_TX_BYTE;
          data_next = value_q;
          idx_next  = '0;
          if (byte_count >= len_cnt) begin
            mode_next  = rpf_pkg::MODE_IDLE;
            state_next = rpf_pkg::S_TAIL;
          end else begin
            last_next  = 1'b1;
            state_next = rpf_pkg::S_IDLE;
          end
        end
      end

      // crc low, crc high, trailer
      rpf_pkg::S_TAIL: begin
        if (slot_free) begin
          load      = 1'b1;
          kind_next = rpf_pkg::KIND_TX_BYTE;
          priority if (idx == IDX_W'(0)) begin
            data_next = crc[rpf_pkg::DATA_W-1:0];
          end else if (idx == IDX_W'(1)) begin
            data_next = crc[rpf_pkg::CRC_W-1:rpf_pkg::DATA_W];
          end else begin
            data_next = rpf_pkg::PREAMBLE_BYTE;
          end
          idx_next = idx_inc;
          if (idx == IDX_W'(3)) begin
            last_next  = 1'b1;
            idx_next   = '0;
            state_next = rpf_pkg::S_IDLE;
          end
        end
      end

      // buffer read issued at idx
      rpf_pkg::S_RD_ADDR: begin
        state_next = rpf_pkg::S_RD_OUT;
      end

      // replay buffered payload
      rpf_pkg::S_RD_OUT: begin
        if (slot_free) begin
          load       = 1'b1;
          kind_next  = rpf_pkg::KIND_RX_BYTE;
          data_next  = ram_rdata;
          idx_next   = idx_inc;
          state_next = (idx_inc == len_idx) ? rpf_pkg::S_STAT : rpf_pkg::S_RD_ADDR;
        end
      end

      // single status result
      rpf_pkg::S_STAT: begin
        if (slot_free) begin
          load        = 1'b1;
          kind_next   = rpf_pkg::KIND_STATUS;
          data_next   = stat_data;
          status_next = stat_code;
          last_next   = 1'b1;
          state_next  = rpf_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rpf_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
